[src/ssnr_pkg.sv]
// ----------------------------------------------------------------------------
// ssnr_pkg: shared definitions for the seven-segment number rectangle unit
// Field widths, register map, segment codes, glyph table and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package ssnr_pkg;

  // Field widths of the two channels, the scale and the glyph box.
  localparam int unsigned OriginW = 12;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned ColorW  = 32;
  localparam int unsigned CoordW  = 13;
  localparam int unsigned ScaleW  = 4;
  localparam int unsigned BoxW    = 7;

  // Default number of decimal digits shown.
  localparam int unsigned MaxDigitsDef = 6;

  // Configuration port: one register, addressed by paddr[2].
  localparam int unsigned PAddrW = 3;
  localparam int unsigned PDataW = 32;
  localparam logic RegGlyphScale = 1'b0;
  localparam logic [ScaleW-1:0] ScaleRst = 4'd1;

  // Reciprocal of ten: floor(v * Recip10 / 2^35) equals v / 10 for 32-bit v.
  localparam logic [31:0] Recip10   = 32'hCCCC_CCCD;
  localparam int unsigned RecipShift = 35;

  // Segment codes, a to g.
  localparam logic [2:0] SegA = 3'd0;
  localparam logic [2:0] SegB = 3'd1;
  localparam logic [2:0] SegC = 3'd2;
  localparam logic [2:0] SegD = 3'd3;
  localparam logic [2:0] SegE = 3'd4;
  localparam logic [2:0] SegF = 3'd5;
  localparam logic [2:0] SegG = 3'd6;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_REM,
    ST_EMIT
  } ssnr_state_e;

  // One rectangle with inclusive corners.
  typedef struct packed {
    logic [CoordW-1:0] left;
    logic [CoordW-1:0] top;
    logic [CoordW-1:0] right;
    logic [CoordW-1:0] bottom;
  } ssnr_rect_t;

  // Largest value that fits in the given number of digits.
  function automatic logic [33:0] pow10_minus1(input int unsigned digits);
    logic [33:0] acc;
    acc = 34'd1;
    for (int unsigned i = 0; i < digits; i++) begin
      acc = acc * 34'd10;
    end
    return acc - 34'd1;
  endfunction

  // Lit segments of a digit, bit 0 is segment a.
  function automatic logic [6:0] glyph_bits(input logic [3:0] digit);
    logic [6:0] bits;
    case (digit)
      4'd1:    bits = 7'h06;
      4'd2:    bits = 7'h5B;
      4'd3:    bits = 7'h4F;
      4'd4:    bits = 7'h66;
      4'd5:    bits = 7'h6D;
      4'd6:    bits = 7'h7D;
      4'd7:    bits = 7'h07;
      4'd8:    bits = 7'h7F;
      4'd9:    bits = 7'h6F;
      default: bits = 7'h3F;
    endcase
    return bits;
  endfunction

endpackage

`default_nettype wire

[src/ssnr_chan_if.sv]
// ----------------------------------------------------------------------------
// ssnr_chan_if: valid/ready channels of the seven-segment number unit
// One interface for the number items, one for the rectangle results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssnr_in_if import ssnr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OriginW-1:0] origin_x;
  logic [OriginW-1:0] origin_y;
  logic [ValueW-1:0]  number_value;
  logic [ColorW-1:0]  ink_color;

  modport source (
    output valid, origin_x, origin_y, number_value, ink_color,
    input  ready
  );
  modport sink (
    input  valid, origin_x, origin_y, number_value, ink_color,
    output ready
  );
endinterface

interface ssnr_out_if import ssnr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CoordW-1:0] rect_left;
  logic [CoordW-1:0] rect_top;
  logic [CoordW-1:0] rect_right;
  logic [CoordW-1:0] rect_bottom;
  logic [ColorW-1:0] rect_color;
  logic              last_rect;

  modport source (
    output valid, rect_left, rect_top, rect_right, rect_bottom, rect_color, last_rect,
    input  ready
  );
  modport sink (
    input  valid, rect_left, rect_top, rect_right, rect_bottom, rect_color, last_rect,
    output ready
  );
endinterface

`default_nettype wire

[src/seven_segment_number_rects_unit.sv]
// ----------------------------------------------------------------------------
// seven_segment_number_rects_unit: seven-segment number renderer
// Clamps a value, splits it into decimal digits and emits one filled
// rectangle for every lit segment, least significant digit first.
// ----------------------------------------------------------------------------
//
//   Port       Dir   Transfer
//   in_chan    sink  one number: origin_x, origin_y, number_value, ink_color
//   out_chan   src   one rectangle: corners, rect_color, last_rect
//   APB        cfg   register 0 at byte address 0: glyph_scale (4 bits)
//
// A number passes digit by digit through the divide-by-ten unit (ST_MUL,
// then ST_REM) and then through the sweep of seven segments per digit,
// one segment a cycle unless out_chan stalls. in_chan.ready is high only
// while the sequencer is idle. A stalled out_chan holds the sweep at the
// current segment. Reset sets glyph_scale to 1 and leaves the sequencer
// idle; with a glyph_scale of 0 a number is taken and yields no rectangles.
// ----------------------------------------------------------------------------
`default_nettype none

module seven_segment_number_rects_unit import ssnr_pkg::*; #(
  parameter int unsigned MAX_DIGITS = MaxDigitsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  ssnr_in_if.sink                in_chan,
  ssnr_out_if.source             out_chan,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PAddrW-1:0] paddr,
  input  wire logic [PDataW-1:0] pwdata,
  output logic [PDataW-1:0]      prdata,
  output logic                   pready
);

  localparam int unsigned CntW = $clog2(MAX_DIGITS + 1);
  localparam int unsigned IdxW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [33:0] ClampBound = pow10_minus1(MAX_DIGITS);

  ssnr_state_e state_q, state_d;

  logic [ScaleW-1:0]  scale_q;
  logic [ValueW-1:0]  val_q;
  logic [CntW-1:0]    ndig_q;
  logic [CntW-1:0]    dcur_q;
  logic [2:0]         seg_q;
  logic [CoordW-1:0]  dx_q;
  logic [OriginW-1:0] oy_q;
  logic [ColorW-1:0]  color_q;
  logic [3:0]         digit_q [MAX_DIGITS];

  logic               out_valid_q;
  ssnr_rect_t         out_rect_q;
  logic [ColorW-1:0]  out_color_q;
  logic               out_last_q;

  logic               in_fire;
  logic               cfg_wr;
  logic [ValueW-1:0]  clamped;
  logic [ValueW-1:0]  quot;
  logic [3:0]         rem;
  logic [CntW-1:0]    ndig_next;
  logic               more_digits;
  logic [BoxW-1:0]    advance;
  logic [3:0]         cur_digit;
  logic [6:0]         cur_bits;
  logic [6:0]         upper_bits;
  logic               seg_lit;
  logic               last_digit;
  logic               seg_end;
  logic               sweep_done;
  ssnr_rect_t         rect;

  // Sequencer controls.
  logic               load_item;
  logic               div_en;
  logic               store_digit;
  logic               sweep_step;

  // --------------------------------------------------------------------------
  // Configuration port.
  // --------------------------------------------------------------------------
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == RegGlyphScale);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegGlyphScale) ? PDataW'(scale_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ScaleRst;
    end else if (cfg_wr) begin
      scale_q <= pwdata[ScaleW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Shared divide-by-ten unit and segment geometry.
  // --------------------------------------------------------------------------
  ssnr_div10 u_div10 (
    .clk_i      (clk_i),
    .en_i       (div_en),
    .dividend_i (val_q),
    .quotient_o (quot),
    .rem_o      (rem)
  );

  ssnr_rect u_rect (
    .scale_i (scale_q),
    .seg_i   (seg_q),
    .dx_i    (dx_q),
    .oy_i    (oy_q),
    .rect_o  (rect)
  );

  // --------------------------------------------------------------------------
  // Status terms.
  // --------------------------------------------------------------------------
  assign in_fire     = in_chan.valid && in_chan.ready;
  assign clamped     = ({2'b00, in_chan.number_value} > ClampBound) ?
                       ClampBound[ValueW-1:0] : in_chan.number_value;
  assign ndig_next   = ndig_q + CntW'(1);
  assign more_digits = (quot != '0) && (ndig_next < CntW'(MAX_DIGITS));
  // Digit advance is 7s, the same as the glyph height.
  assign advance     = {scale_q, 3'b000} - BoxW'(scale_q);

  assign cur_digit   = digit_q[dcur_q[IdxW-1:0]];
  assign cur_bits    = glyph_bits(cur_digit);
  assign upper_bits  = cur_bits >> seg_q;
  assign seg_lit     = upper_bits[0];
  assign last_digit  = (dcur_q == ndig_q - CntW'(1));
  assign seg_end     = (seg_q == SegG);
  assign sweep_done  = last_digit && seg_end;

  // --------------------------------------------------------------------------
  // Next-state logic.
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && (scale_q != '0)) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_REM;
      end
      ST_REM: begin
        state_d = more_digits ? ST_MUL : ST_EMIT;
      end
      ST_EMIT: begin
        if (sweep_step && sweep_done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control outputs of the sequencer.
  // --------------------------------------------------------------------------
  always_comb begin
    load_item   = 1'b0;
    div_en      = 1'b0;
    store_digit = 1'b0;
    sweep_step  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        load_item = in_fire && (scale_q != '0);
      end
      ST_MUL: begin
        div_en = 1'b1;
      end
      ST_REM: begin
        store_digit = 1'b1;
      end
      ST_EMIT: begin
        sweep_step = !out_valid_q || out_chan.ready;
      end
      default: begin
        load_item = 1'b0;
      end
    endcase
  end

  assign in_chan.ready = (state_q == ST_IDLE);

  // --------------------------------------------------------------------------
  // Control registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ndig_q      <= '0;
      dcur_q      <= '0;
      seg_q       <= SegA;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (load_item) begin
        ndig_q <= '0;
      end else if (store_digit) begin
        ndig_q <= ndig_next;
      end

      // Segment sweep over every digit, one segment a cycle unless out_chan stalls.
      if (store_digit) begin
        dcur_q <= '0;
        seg_q  <= SegA;
      end else if (sweep_step) begin
        if (seg_end) begin
          seg_q  <= SegA;
          dcur_q <= sweep_done ? '0 : dcur_q + CntW'(1);
        end else begin
          seg_q <= seg_q + 3'd1;
        end
      end

      // The output register fills on a lit segment and empties on a transfer.
      if (sweep_step && seg_lit) begin
        out_valid_q <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Item and digit payload.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (load_item) begin
      val_q   <= clamped;
      dx_q    <= CoordW'(in_chan.origin_x);
      oy_q    <= in_chan.origin_y;
      color_q <= in_chan.ink_color;
    end else if (store_digit) begin
      val_q <= quot;
      // The least significant digit sits one advance further right for each extra digit.
      if (more_digits) begin
        dx_q <= dx_q + CoordW'(advance);
      end
    end else if (sweep_step && seg_end) begin
      dx_q <= dx_q - CoordW'(advance);
    end

    if (store_digit) begin
      digit_q[ndig_q[IdxW-1:0]] <= rem;
    end
  end

  // --------------------------------------------------------------------------
  // Output register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (sweep_step && seg_lit) begin
      out_rect_q  <= rect;
      out_color_q <= color_q;
      out_last_q  <= last_digit && (upper_bits[6:1] == 6'd0);
    end
  end

  assign out_chan.valid       = out_valid_q;
  assign out_chan.rect_left   = out_rect_q.left;
  assign out_chan.rect_top    = out_rect_q.top;
  assign out_chan.rect_right  = out_rect_q.right;
  assign out_chan.rect_bottom = out_rect_q.bottom;
  assign out_chan.rect_color  = out_color_q;
  assign out_chan.last_rect   = out_last_q;

endmodule

`default_nettype wire

[src/ssnr_div10.sv]
// ----------------------------------------------------------------------------
// ssnr_div10: divide-by-ten unit
// Registers the reciprocal product; quotient and remainder follow
// from the held product and the dividend in the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ssnr_div10 import ssnr_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic [ValueW-1:0] dividend_i,
  output logic [ValueW-1:0]      quotient_o,
  output logic [3:0]             rem_o
);

  localparam int unsigned QuotW = 2 * ValueW - RecipShift;

  logic [2*ValueW-1:0] prod_q;
  logic [QuotW-1:0]    quot;
  logic [3:0]          quot10_lo;

  // Multiply by the reciprocal; the product is held for the next cycle.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= (2*ValueW)'(dividend_i) * (2*ValueW)'(Recip10);
    end
  end

  // The remainder is below ten, so four bits of dividend - 10*q suffice.
  assign quot       = prod_q[2*ValueW-1:RecipShift];
  assign quot10_lo  = {quot[0], 3'b000} + {quot[2:0], 1'b0};
  assign quotient_o = ValueW'(quot);
  assign rem_o      = dividend_i[3:0] - quot10_lo;

endmodule

`default_nettype wire

[src/ssnr_rect.sv]
// ----------------------------------------------------------------------------
// ssnr_rect: segment rectangle generator
// Works out one segment's box from the scale and places it at the digit
// origin.
// ----------------------------------------------------------------------------
`default_nettype none

module ssnr_rect import ssnr_pkg::*; (
  input  wire logic [ScaleW-1:0]  scale_i,
  input  wire logic [2:0]         seg_i,
  input  wire logic [CoordW-1:0]  dx_i,
  input  wire logic [OriginW-1:0] oy_i,
  output ssnr_rect_t              rect_o
);

  logic [2:0]      thick;
  logic [1:0]      half_thick;
  logic [BoxW-1:0] wid;
  logic [BoxW-1:0] hgt;
  logic [BoxW-1:0] mid;
  logic [BoxW-1:0] bx0, by0, bx1, by1;

  // Stroke thickness is at least one; glyph is 5s wide and 7s high.
  always_comb begin
    thick      = (scale_i[ScaleW-1:1] == 3'd0) ? 3'd1 : scale_i[ScaleW-1:1];
    half_thick = thick[2:1];
    wid        = {1'b0, scale_i, 2'b00} + BoxW'(scale_i);
    hgt        = {scale_i, 3'b000} - BoxW'(scale_i);
    mid        = {1'b0, hgt[BoxW-1:1]};
  end

  // Segment box relative to the digit origin.
  always_comb begin
    bx0 = '0;
    by0 = '0;
    bx1 = wid;
    by1 = hgt;
    case (seg_i)
      SegA: begin
        by1 = BoxW'(thick) - 7'd1;
      end
      SegB: begin
        bx0 = wid - BoxW'(thick) + 7'd1;
        by1 = mid - 7'd1;
      end
      SegC: begin
        bx0 = wid - BoxW'(thick) + 7'd1;
        by0 = mid + 7'd1;
      end
      SegD: begin
        by0 = hgt - BoxW'(thick) + 7'd1;
      end
      SegE: begin
        by0 = mid + 7'd1;
        bx1 = BoxW'(thick) - 7'd1;
      end
      SegF: begin
        bx1 = BoxW'(thick) - 7'd1;
        by1 = mid - 7'd1;
      end
      default: begin
        by0 = mid - BoxW'(half_thick);
        by1 = mid + BoxW'(half_thick);
      end
    endcase
  end

  // Place the box at the digit origin.
  always_comb begin
    rect_o.left   = dx_i + CoordW'(bx0);
    rect_o.right  = dx_i + CoordW'(bx1);
    rect_o.top    = CoordW'(oy_i) + CoordW'(by0);
    rect_o.bottom = CoordW'(oy_i) + CoordW'(by1);
  end

endmodule

`default_nettype wire

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the seven-segment number rectangle unit
// Numbers are sent over the input channel while a shadow of the glyph scale
// predicts every segment rectangle. The output channel is compared field by
// field against that prediction. Both channels stall in random bursts, and the
// scale register is reprogrammed between phases over the APB port.
// ----------------------------------------------------------------------------
module tb_top;
  import ssnr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxDigits   = MaxDigitsDef;
  localparam int unsigned ValueClamp  = 999_999;
  localparam int unsigned DrainCycles = 64;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned ItemsPerSet = 19;

  // One number to render.
  typedef struct packed {
    logic [OriginW-1:0] org_x;
    logic [OriginW-1:0] org_y;
    logic [ValueW-1:0]  value;
    logic [ColorW-1:0]  ink;
  } number_item_t;

  // One rectangle as it should leave the block.
  typedef struct packed {
    ssnr_rect_t        box;
    logic [ColorW-1:0] color;
    logic              last;
  } seg_rect_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Values driven onto the channels and the register port.
  logic               num_valid  = 1'b0;
  logic [OriginW-1:0] num_x      = '0;
  logic [OriginW-1:0] num_y      = '0;
  logic [ValueW-1:0]  num_value  = '0;
  logic [ColorW-1:0]  num_ink    = '0;
  logic               rect_ready = 1'b0;
  logic               apb_sel    = 1'b0;
  logic               apb_en     = 1'b0;
  logic               apb_wr     = 1'b0;
  logic [PAddrW-1:0]  apb_addr   = '0;
  logic [PDataW-1:0]  apb_wdata  = '0;
  logic [PDataW-1:0]  apb_rdata;
  logic               apb_ready;

  number_item_t      numbers_pending[$];
  seg_rect_t         rects_due[$];
  logic [ScaleW-1:0] scale_now   = ScaleRst;
  bit                idling_on   = 1'b1;
  bit                drain_hold  = 1'b0;
  int                send_gap    = 0;
  int                take_gap    = 0;
  int                mismatches  = 0;
  int unsigned       cycle_count = 0;

  ssnr_in_if  in_chan ();
  ssnr_out_if out_chan ();

  assign in_chan.valid        = num_valid;
  assign in_chan.origin_x     = num_x;
  assign in_chan.origin_y     = num_y;
  assign in_chan.number_value = num_value;
  assign in_chan.ink_color    = num_ink;
  assign out_chan.ready       = rect_ready;

  seven_segment_number_rects_unit dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (apb_sel),
    .penable  (apb_en),
    .pwrite   (apb_wr),
    .paddr    (apb_addr),
    .pwdata   (apb_wdata),
    .prdata   (apb_rdata),
    .pready   (apb_ready)
  );

  always #5ns clk_i = ~clk_i;

  // Work out every rectangle of one number and queue them in output order.
  function automatic void render_number(input number_item_t item,
                                        input logic [ScaleW-1:0] s);
    logic [3:0]  digits [MaxDigits];
    logic [31:0] rest;
    logic [6:0]  lit;
    logic [2:0]  seg;
    int unsigned ndig, t, w, h, hm, dx, x0, y0, x1, y1;
    int unsigned first;
    seg_rect_t   r;
    rest = (item.value > ValueClamp) ? ValueClamp : item.value;
    digits[0] = 4'(rest % 10);
    rest = rest / 10;
    ndig = 1;
    while (rest != 0 && ndig < MaxDigits) begin
      digits[ndig] = 4'(rest % 10);
      rest = rest / 10;
      ndig++;
    end
    // A zero scale swallows the number without drawing anything.
    if (s == 0) return;
    t  = (s / 2 < 1) ? 1 : s / 2;
    w  = 5 * s;
    h  = 7 * s;
    hm = h / 2;
    first = rects_due.size();
    for (int k = 0; k < ndig; k++) begin
      case (digits[k])
        4'd1:    lit = 7'h06;
        4'd2:    lit = 7'h5B;
        4'd3:    lit = 7'h4F;
        4'd4:    lit = 7'h66;
        4'd5:    lit = 7'h6D;
        4'd6:    lit = 7'h7D;
        4'd7:    lit = 7'h07;
        4'd8:    lit = 7'h7F;
        4'd9:    lit = 7'h6F;
        default: lit = 7'h3F;
      endcase
      // The least significant digit sits furthest to the right.
      dx = item.org_x + (ndig - 1 - k) * 7 * s;
      for (int i = 0; i < 7; i++) begin
        seg = 3'(i);
        if (lit[seg]) begin
          case (seg)
            SegA:    begin x0 = 0;         y0 = 0;          x1 = w;     y1 = t - 1;      end
            SegB:    begin x0 = w - t + 1; y0 = 0;          x1 = w;     y1 = hm - 1;     end
            SegC:    begin x0 = w - t + 1; y0 = hm + 1;     x1 = w;     y1 = h;          end
            SegD:    begin x0 = 0;         y0 = h - t + 1;  x1 = w;     y1 = h;          end
            SegE:    begin x0 = 0;         y0 = hm + 1;     x1 = t - 1; y1 = h;          end
            SegF:    begin x0 = 0;         y0 = 0;          x1 = t - 1; y1 = hm - 1;     end
            default: begin x0 = 0;         y0 = hm - t / 2; x1 = w;     y1 = hm + t / 2; end
          endcase
          r.box.left   = CoordW'(dx + x0);
          r.box.top    = CoordW'(item.org_y + y0);
          r.box.right  = CoordW'(dx + x1);
          r.box.bottom = CoordW'(item.org_y + y1);
          r.color      = item.ink;
          r.last       = 1'b0;
          rects_due.push_back(r);
        end
      end
    end
    if (rects_due.size() > first) begin
      r = rects_due.pop_back();
      r.last = 1'b1;
      rects_due.push_back(r);
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // One APB transfer: setup cycle, then access cycle. Reads of the scale
  // register are checked against the shadow copy.
  task automatic apb_xfer(input logic wr, input logic [PAddrW-1:0] addr,
                          input logic [PDataW-1:0] data);
    @(posedge clk_i);
    apb_sel   <= 1'b1;
    apb_en    <= 1'b0;
    apb_wr    <= wr;
    apb_addr  <= addr;
    apb_wdata <= data;
    @(posedge clk_i);
    apb_en <= 1'b1;
    @(negedge clk_i);
    if (!wr && addr[2] == RegGlyphScale) begin
      check_field("glyph_scale", 32'(scale_now), 32'(apb_rdata[ScaleW-1:0]));
    end
    @(posedge clk_i);
    if (wr && addr[2] == RegGlyphScale) scale_now = data[ScaleW-1:0];
    apb_sel <= 1'b0;
    apb_en  <= 1'b0;
  endtask

  // Hold off until every sent number has been rendered and the unit has had
  // time to finish any number that draws nothing.
  task automatic settle();
    while (numbers_pending.size() != 0 || num_valid || rects_due.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Program the scale with junk in the unused upper bits, then read it back.
  task automatic set_scale(input logic [ScaleW-1:0] s);
    logic [PDataW-1:0] data;
    settle();
    data = $urandom();
    data[ScaleW-1:0] = s;
    apb_xfer(1'b1, '0, data);
    apb_xfer(1'b0, '0, '0);
  endtask

  task automatic queue_number(input logic [OriginW-1:0] x, input logic [OriginW-1:0] y,
                              input logic [ValueW-1:0] v, input logic [ColorW-1:0] c);
    numbers_pending.push_back('{org_x: x, org_y: y, value: v, ink: c});
  endtask

  // Driver: on each number transfer the rectangles are predicted, then the
  // next number is offered unless a gap or a drain pause is in force.
  always @(posedge clk_i) begin : drive_numbers
    logic         next_valid;
    number_item_t item;
    if (rst_ni) begin
      next_valid = num_valid;
      if (num_valid && in_chan.ready) begin
        render_number('{org_x: num_x, org_y: num_y, value: num_value, ink: num_ink},
                      scale_now);
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (drain_hold && rects_due.size() == 0) drain_hold = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (!drain_hold && numbers_pending.size() != 0) begin
          if (idling_on && $urandom_range(0, 6) == 0) begin
            send_gap = $urandom_range(1, 14) - 1;
          end else if (idling_on && $urandom_range(0, 29) == 0) begin
            drain_hold = 1'b1;
          end else begin
            item = numbers_pending.pop_front();
            num_x      <= item.org_x;
            num_y      <= item.org_y;
            num_value  <= item.value;
            num_ink    <= item.ink;
            next_valid = 1'b1;
          end
        end
      end
      num_valid <= next_valid;
    end
  end

  // Monitor: each rectangle transfer is checked against the oldest
  // prediction, and the ready line stalls in random bursts.
  always @(posedge clk_i) begin : check_rects
    seg_rect_t want;
    logic      next_ready;
    if (rst_ni) begin
      if (out_chan.valid && rect_ready) begin
        if (rects_due.size() == 0) begin
          $error("rectangle (%0d,%0d)-(%0d,%0d) arrived with none expected",
                 out_chan.rect_left, out_chan.rect_top,
                 out_chan.rect_right, out_chan.rect_bottom);
          mismatches++;
        end else begin
          want = rects_due.pop_front();
          check_field("rect_left", 32'(want.box.left), 32'(out_chan.rect_left));
          check_field("rect_top", 32'(want.box.top), 32'(out_chan.rect_top));
          check_field("rect_right", 32'(want.box.right), 32'(out_chan.rect_right));
          check_field("rect_bottom", 32'(want.box.bottom), 32'(out_chan.rect_bottom));
          check_field("rect_color", want.color, out_chan.rect_color);
          check_field("last_rect", 32'(want.last), 32'(out_chan.last_rect));
        end
      end
      if (take_gap > 0) begin
        take_gap--;
        next_ready = 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        take_gap = $urandom_range(1, 14) - 1;
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      rect_ready <= next_ready;
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : run_phases
    logic [ScaleW-1:0]  scale_plan [11];
    logic [OriginW-1:0] x, y;
    logic [ValueW-1:0]  v;
    int unsigned        nd, lo, hi;
    scale_plan = '{4'd1, 4'd15, 4'd7, 4'd2, 4'd0, 4'd4, 4'd11, 4'd3, 4'd9, 4'd15, 4'd1};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset scale, then numbers covering every digit, the clamp and the
    // coordinate and colour extremes.
    apb_xfer(1'b0, '0, '0);
    queue_number(12'h000, 12'h000, 32'd0, 32'h0000_0000);
    queue_number(12'hFFF, 12'hFFF, 32'd123456, 32'hFFFF_FFFF);
    queue_number(12'h000, 12'hFFF, 32'd7890, 32'hA5A5_A5A5);
    queue_number(12'hFFF, 12'h000, 32'd999999, 32'h5A5A_5A5A);
    queue_number(12'd100, 12'd200, 32'd1000000, 32'h1234_5678);
    queue_number(12'd555, 12'd777, 32'hFFFF_FFFF, 32'h8000_0001);
    queue_number(12'hAAA, 12'h555, 32'd8, 32'h7FFF_FFFE);
    queue_number(12'h555, 12'hAAA, 32'd1, 32'hDEAD_BEEF);

    // Largest scale with the furthest-reaching numbers.
    set_scale(4'd15);
    queue_number(12'hFFF, 12'hFFF, 32'd999999, 32'hFFFF_FFFF);
    queue_number(12'h000, 12'h000, 32'd888888, 32'h0000_0000);
    queue_number(12'hFFF, 12'h000, 32'd0, 32'hCAFE_F00D);
    queue_number(12'd123, 12'd456, 32'hFFFF_FFFF, 32'h0F0F_0F0F);

    // Zero scale draws nothing; a write to the unused register index is
    // dropped.
    set_scale(4'd0);
    queue_number(12'd10, 12'd20, 32'd888888, 32'h1111_1111);
    queue_number(12'hFFF, 12'hFFF, 32'd5, 32'h2222_2222);
    settle();
    apb_xfer(1'b1, 3'b100, $urandom());
    apb_xfer(1'b0, '0, '0);
    queue_number(12'd40, 12'd50, 32'd42, 32'h3333_3333);

    set_scale(4'd2);
    queue_number(12'd10, 12'd10, 32'd2468, 32'h4444_4444);
    queue_number(12'd4000, 12'd4000, 32'd13579, 32'h5555_5555);
    set_scale(4'd3);
    queue_number(12'd0, 12'd0, 32'd1000000, 32'h6666_6666);

    // Random numbers, one batch per scale; the final batch runs without
    // stalls.
    for (int p = 0; p < 11; p++) begin
      set_scale(scale_plan[p]);
      idling_on = (p == 10) ? 1'b0 : ($urandom_range(0, 3) != 0);
      for (int i = 0; i < ItemsPerSet; i++) begin
        x = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 12'hFFF : 12'h000)
                                        : 12'($urandom());
        y = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 12'hFFF : 12'h000)
                                        : 12'($urandom());
        case ($urandom_range(0, 9))
          0: v = $urandom();
          1: v = ValueClamp - 1 + $urandom_range(0, 2);
          default: begin
            nd = $urandom_range(1, MaxDigits);
            lo = 1;
            repeat (nd - 1) lo = lo * 10;
            hi = lo * 10 - 1;
            if (nd == 1) lo = 0;
            v = $urandom_range(hi, lo);
          end
        endcase
        queue_number(x, y, v, $urandom());
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
